// ===== rtl/core/dapqm_pkg.sv =====
`timescale 1ns / 1ps

package dapqm_pkg;

    // Number of controlled axes: roll is axis 0, pitch is axis 1.
    localparam int AXES   = 2;
    localparam int AXIS_W = $clog2(AXES);

    // Fixed point formats.
    localparam int DATA_W = 32;               // Q16.16 angles, thrust, forces
    localparam int GAIN_W = 16;               // Q8.8 gains
    localparam int FRAC_W = 16;               // fraction bits of Q16.16
    localparam int GAIN_FRAC_W = 8;           // fraction bits of Q8.8
    localparam int MIX_SHIFT = 2;             // divide by four in the mixer

    // Datapath widths.
    localparam int DIFF_W = DATA_W + 1;       // exact difference of two words
    localparam int MUL_W  = DATA_W + 1;       // multiplier operand width
    localparam int PROD_W = 2 * MUL_W;        // full signed product
    localparam int ACC_W  = 52;               // sum of three Q8.8 x Q16.16 terms
    localparam int MIX_W  = DATA_W + 3;       // thrust +/- 2*cp +/- 2*cr
    localparam int WIDE_W = PROD_W + 2;       // common width for saturation

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0] KP_RESET   = 16'sd2560;
    localparam logic signed [GAIN_W-1:0] KI_RESET   = 16'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RESET   = 16'sd2816;
    localparam logic        [DATA_W-1:0] DT_RESET   = 32'd655;
    localparam logic        [DATA_W-1:0] RATE_RESET = 32'd6553600;

    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KI   = 3'd1,
        CFG_KD   = 3'd2,
        CFG_DT   = 3'd3,
        CFG_RATE = 3'd4
    } cfg_idx_t;

    // Microcode store geometry and step addresses.
    localparam int UC_DEPTH = 9;
    localparam int PC_W     = $clog2(UC_DEPTH);

    localparam logic [PC_W-1:0] STEP_ERR     = 4'd0;
    localparam logic [PC_W-1:0] STEP_INT_MUL = 4'd1;
    localparam logic [PC_W-1:0] STEP_INT_WB  = 4'd2;
    localparam logic [PC_W-1:0] STEP_DER_WB  = 4'd3;
    localparam logic [PC_W-1:0] STEP_ACC_P   = 4'd4;
    localparam logic [PC_W-1:0] STEP_ACC_I   = 4'd5;
    localparam logic [PC_W-1:0] STEP_ACC_D   = 4'd6;
    localparam logic [PC_W-1:0] STEP_CMD     = 4'd7;
    localparam logic [PC_W-1:0] STEP_MIX     = 4'd8;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_E_DT,
        MUL_DIFF_RATE,
        MUL_KP_E,
        MUL_KI_I,
        MUL_KD_D
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // Sequencing: advance, loop back once per extra axis, or finish the beat.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_LOOP,
        SEQ_END
    } seq_op_t;

    typedef enum logic {
        SQ_IDLE,
        SQ_RUN
    } sq_state_t;

    typedef struct packed {
        mul_sel_t        mul;
        acc_op_t         acc;
        logic            err_wr;
        logic            int_wr;
        logic            der_wr;
        logic            prev_wr;
        logic            cmd_wr;
        logic            mix_wr;
        seq_op_t         seq;
        logic [PC_W-1:0] target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        mul: MUL_NONE, acc: ACC_NONE, err_wr: 1'b0, int_wr: 1'b0,
        der_wr: 1'b0, prev_wr: 1'b0, cmd_wr: 1'b0, mix_wr: 1'b0,
        seq: SEQ_NEXT, target: STEP_ERR
    };

    // Control from the sequencer to the datapath.
    typedef struct packed {
        ucode_t            uc;
        logic              en;
        logic [AXIS_W-1:0] axis;
        logic              load;
    } dapqm_ctrl_t;

    // Clamp a wide signed value to the 32 bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input wide_t v);
        logic hi_all_one;
        logic hi_any_one;
        hi_all_one = &v[WIDE_W-1:DATA_W-1];
        hi_any_one = |v[WIDE_W-1:DATA_W-1];
        if (hi_all_one || !hi_any_one) begin
            return v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== rtl/core/dual_axis_pid_quad_mixer_core.sv =====
`timescale 1ns / 1ps

// Two-axis PID attitude controller with a four-motor mixer. Each input beat
// is one control tick (roll and pitch targets, measured angles, total thrust,
// all signed Q16.16); each tick yields one result beat of four saturated motor
// forces. After taking the beat, a tick runs 17 microcode steps, eight per axis
// plus one mix step, with the single shared 33x33 multiplier handling error*dt,
// the derivative product and the three gain products in turn. The next beat is
// taken while the result is still waiting in the output register; the mix step
// holds if that result has not been taken by then. The user must write gains,
// period and rate through the cfg port only while no tick is in flight; the
// block does not enforce this. The integrator and previous error reset to zero.
module dual_axis_pid_quad_mixer_core
    import dapqm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_target_roll,
    input  logic signed [DATA_W-1:0] s_target_pitch,
    input  logic signed [DATA_W-1:0] s_measured_roll,
    input  logic signed [DATA_W-1:0] s_measured_pitch,
    input  logic signed [DATA_W-1:0] s_thrust_total,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_motor_force_0,
    output logic signed [DATA_W-1:0] m_motor_force_1,
    output logic signed [DATA_W-1:0] m_motor_force_2,
    output logic signed [DATA_W-1:0] m_motor_force_3
);

    logic [PC_W-1:0] pc;
    ucode_t          uc;
    dapqm_ctrl_t     ctrl;

    // Control store.
    dapqm_ucode_rom u_rom (
        .pc (pc),
        .uc (uc)
    );

    // Step counter, axis loop and beat handshakes.
    dapqm_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .pc      (pc),
        .uc      (uc),
        .ctrl    (ctrl)
    );

    // Registers, shared multiplier and mixer.
    dapqm_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_target_roll    (s_target_roll),
        .s_target_pitch   (s_target_pitch),
        .s_measured_roll  (s_measured_roll),
        .s_measured_pitch (s_measured_pitch),
        .s_thrust_total   (s_thrust_total),
        .m_motor_force_0  (m_motor_force_0),
        .m_motor_force_1  (m_motor_force_1),
        .m_motor_force_2  (m_motor_force_2),
        .m_motor_force_3  (m_motor_force_3)
    );

endmodule

// ===== rtl/core/dapqm_ucode_rom.sv =====
`timescale 1ns / 1ps

module dapqm_ucode_rom
    import dapqm_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ucode_t          uc
);

    // Control store. Steps from STEP_ERR to STEP_CMD run once per axis;
    // the loop at STEP_CMD goes back for the pitch axis, then the mixer runs.
    always_comb begin
        uc = UC_NOP;
        case (pc)
            STEP_ERR: begin
                uc.err_wr = 1'b1;
            end
            STEP_INT_MUL: begin
                uc.mul = MUL_E_DT;
            end
            STEP_INT_WB: begin
                uc.mul    = MUL_DIFF_RATE;
                uc.int_wr = 1'b1;
            end
            STEP_DER_WB: begin
                uc.mul     = MUL_KP_E;
                uc.der_wr  = 1'b1;
                uc.prev_wr = 1'b1;
            end
            STEP_ACC_P: begin
                uc.mul = MUL_KI_I;
                uc.acc = ACC_LOAD;
            end
            STEP_ACC_I: begin
                uc.mul = MUL_KD_D;
                uc.acc = ACC_ADD;
            end
            STEP_ACC_D: begin
                uc.acc = ACC_ADD;
            end
            STEP_CMD: begin
                uc.cmd_wr = 1'b1;
                uc.seq    = SEQ_LOOP;
                uc.target = STEP_ERR;
            end
            STEP_MIX: begin
                uc.mix_wr = 1'b1;
                uc.seq    = SEQ_END;
            end
            default: begin
                uc.seq = SEQ_END;
            end
        endcase
    end

endmodule

// ===== rtl/core/dapqm_sequencer.sv =====
`timescale 1ns / 1ps

module dapqm_sequencer
    import dapqm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [PC_W-1:0] pc,
    input  ucode_t          uc,
    output dapqm_ctrl_t     ctrl
);

    sq_state_t         state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              stall;
    logic              step_en;
    logic              last_axis;

    assign last_axis = (axis_reg == AXIS_W'(AXES - 1));

    // The finishing step waits while the previous result beat is still held.
    assign stall   = (uc.seq == SEQ_END) && m_valid_reg && !m_ready;
    assign step_en = (state_reg == SQ_RUN) && !stall;
    assign accept  = (state_reg == SQ_IDLE) && s_valid;

    // Next state, step counter and axis.
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        axis_next  = axis_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (s_valid) begin
                    state_next = SQ_RUN;
                    pc_next    = STEP_ERR;
                    axis_next  = '0;
                end
            end
            SQ_RUN: begin
                if (step_en) begin
                    case (uc.seq)
                        SEQ_NEXT: begin
                            pc_next = pc_reg + PC_W'(1);
                        end
                        SEQ_LOOP: begin
                            if (last_axis) begin
                                pc_next = pc_reg + PC_W'(1);
                            end else begin
                                pc_next   = uc.target;
                                axis_next = axis_reg + AXIS_W'(1);
                            end
                        end
                        SEQ_END: begin
                            pc_next    = STEP_ERR;
                            state_next = SQ_IDLE;
                        end
                        default: begin
                            pc_next    = STEP_ERR;
                            state_next = SQ_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // Result beat valid: set by the mix step, cleared when taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (step_en && (uc.seq == SEQ_END)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready   = 1'b0;
        ctrl.uc   = uc;
        ctrl.en   = 1'b0;
        ctrl.axis = axis_reg;
        ctrl.load = accept;
        case (state_reg)
            SQ_IDLE: begin
                s_ready = 1'b1;
            end
            SQ_RUN: begin
                ctrl.en = step_en;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= SQ_IDLE;
            pc_reg      <= STEP_ERR;
            axis_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign pc      = pc_reg;
    assign m_valid = m_valid_reg;

`ifndef NO_ASSERTIONS
    // A new result beat appears only out of the mix step.
    a_valid_from_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(pc_reg == STEP_MIX && state_reg == SQ_RUN))
        else $error("result valid rose outside the mix step");

    // The mixer runs only after every axis has been computed.
    a_mix_last_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_RUN && pc_reg == STEP_MIX) |-> last_axis)
        else $error("mix step reached before the last axis");

    // The step counter stays inside the control store while running.
    a_pc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SQ_RUN) |-> (pc_reg <= STEP_MIX))
        else $error("step counter left the control store");

    // A held result beat is never overwritten by the mix step.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(ctrl.en && ctrl.uc.mix_wr))
        else $error("mix step fired while a result beat was pending");
`endif

endmodule

// ===== rtl/core/dapqm_datapath.sv =====
`timescale 1ns / 1ps

module dapqm_datapath
    import dapqm_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dapqm_ctrl_t                    ctrl,
    input  logic                           cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_wr_data,
    input  logic signed [DATA_W-1:0]       s_target_roll,
    input  logic signed [DATA_W-1:0]       s_target_pitch,
    input  logic signed [DATA_W-1:0]       s_measured_roll,
    input  logic signed [DATA_W-1:0]       s_measured_pitch,
    input  logic signed [DATA_W-1:0]       s_thrust_total,
    output logic signed [DATA_W-1:0]       m_motor_force_0,
    output logic signed [DATA_W-1:0]       m_motor_force_1,
    output logic signed [DATA_W-1:0]       m_motor_force_2,
    output logic signed [DATA_W-1:0]       m_motor_force_3
);

    // Configuration registers.
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic        [DATA_W-1:0] dt_reg, rate_reg;

    // Captured input beat.
    logic signed [DATA_W-1:0] tgt_reg  [AXES];
    logic signed [DATA_W-1:0] meas_reg [AXES];
    logic signed [DATA_W-1:0] thrust_reg;

    // Controller state and working registers.
    logic signed [DATA_W-1:0] integ_reg [AXES];
    logic signed [DATA_W-1:0] prev_reg  [AXES];
    logic signed [DATA_W-1:0] cmd_reg   [AXES];
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] der_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] force_reg [4];

    logic signed [DIFF_W-1:0] err_raw;
    logic signed [DIFF_W-1:0] err_diff;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [ACC_W-1:0]  prod_low;
    logic signed [ACC_W-1:0]  acc_shr;
    logic signed [DATA_W-1:0] int_next;
    logic signed [DATA_W-1:0] err_next;
    logic signed [DATA_W-1:0] der_next;
    logic signed [DATA_W-1:0] cmd_next;
    logic signed [MIX_W-1:0]  mix_thr, mix_cr, mix_cp;
    logic signed [MIX_W-1:0]  mix_sum [4];
    logic signed [MIX_W-1:0]  mix_shr [4];

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= KP_RESET;
            ki_reg   <= KI_RESET;
            kd_reg   <= KD_RESET;
            dt_reg   <= DT_RESET;
            rate_reg <= RATE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_KP:   kp_reg   <= $signed(cfg_wr_data[GAIN_W-1:0]);
                CFG_KI:   ki_reg   <= $signed(cfg_wr_data[GAIN_W-1:0]);
                CFG_KD:   kd_reg   <= $signed(cfg_wr_data[GAIN_W-1:0]);
                CFG_DT:   dt_reg   <= cfg_wr_data[DATA_W-1:0];
                CFG_RATE: rate_reg <= cfg_wr_data[DATA_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the input beat when it is accepted.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            tgt_reg[0]  <= s_target_roll;
            tgt_reg[1]  <= s_target_pitch;
            meas_reg[0] <= s_measured_roll;
            meas_reg[1] <= s_measured_pitch;
            thrust_reg  <= s_thrust_total;
        end
    end

    // Error of the current axis and its change since the last tick.
    assign err_raw  = DIFF_W'(tgt_reg[ctrl.axis]) - DIFF_W'(meas_reg[ctrl.axis]);
    assign err_next = sat32(wide_t'(err_raw));
    assign err_diff = DIFF_W'(err_reg) - DIFF_W'(prev_reg[ctrl.axis]);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.uc.mul)
            MUL_E_DT: begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            MUL_DIFF_RATE: begin
                mul_a = err_diff;
                mul_b = $signed({1'b0, rate_reg});
            end
            MUL_KP_E: begin
                mul_a = MUL_W'(kp_reg);
                mul_b = MUL_W'(err_reg);
            end
            MUL_KI_I: begin
                mul_a = MUL_W'(ki_reg);
                mul_b = MUL_W'(integ_reg[ctrl.axis]);
            end
            MUL_KD_D: begin
                mul_a = MUL_W'(kd_reg);
                mul_b = MUL_W'(der_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Write-back arithmetic on the registered product.
    assign prod_shr = prod_reg >>> FRAC_W;
    assign prod_low = $signed(prod_reg[ACC_W-1:0]);
    assign int_next = sat32(wide_t'(integ_reg[ctrl.axis]) + wide_t'(prod_shr));
    assign der_next = sat32(wide_t'(prod_shr));
    assign acc_shr  = acc_reg >>> GAIN_FRAC_W;
    assign cmd_next = sat32(wide_t'(acc_shr));

    // Motor mix: each force is (T +/- 2*cp +/- 2*cr) / 4, floored.
    assign mix_thr = MIX_W'(thrust_reg);
    assign mix_cr  = MIX_W'(cmd_reg[0]) <<< 1;
    assign mix_cp  = MIX_W'(cmd_reg[1]) <<< 1;

    assign mix_sum[0] = mix_thr - mix_cp - mix_cr;
    assign mix_sum[1] = mix_thr - mix_cp + mix_cr;
    assign mix_sum[2] = mix_thr + mix_cp - mix_cr;
    assign mix_sum[3] = mix_thr + mix_cp + mix_cr;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mix_shr[i] = mix_sum[i] >>> MIX_SHIFT;
        end
    end

    // Working registers, updated by the current control word.
    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            if (ctrl.uc.err_wr) begin
                err_reg <= err_next;
            end
            if (ctrl.uc.mul != MUL_NONE) begin
                prod_reg <= prod_next;
            end
            if (ctrl.uc.der_wr) begin
                der_reg <= der_next;
            end
            case (ctrl.uc.acc)
                ACC_LOAD: acc_reg <= prod_low;
                ACC_ADD:  acc_reg <= acc_reg + prod_low;
                default: begin
                end
            endcase
            if (ctrl.uc.cmd_wr) begin
                cmd_reg[ctrl.axis] <= cmd_next;
            end
            if (ctrl.uc.mix_wr) begin
                for (int i = 0; i < 4; i++) begin
                    force_reg[i] <= sat32(wide_t'(mix_shr[i]));
                end
            end
        end
    end

    // Controller state carried from tick to tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXES; i++) begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end else if (ctrl.en) begin
            if (ctrl.uc.int_wr) begin
                integ_reg[ctrl.axis] <= int_next;
            end
            if (ctrl.uc.prev_wr) begin
                prev_reg[ctrl.axis] <= err_reg;
            end
        end
    end

    assign m_motor_force_0 = force_reg[0];
    assign m_motor_force_1 = force_reg[1];
    assign m_motor_force_2 = force_reg[2];
    assign m_motor_force_3 = force_reg[3];

endmodule
